@@ rtl/core/pf2a_pkg.sv @@
// Shared types and constants of the pixel format converter.
`default_nettype none
package pf2a_pkg;

  localparam int unsigned PaletteDepthDefault = 256;

  localparam int unsigned ColorW   = 24;
  localparam int unsigned PixelW   = 32;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned CountW   = 9;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [PixelW-1:0] AlphaOpaque = 32'hff00_0000;

  // Source formats
  localparam logic [ModeW-1:0] ModePalette = 2'd0;
  localparam logic [ModeW-1:0] ModeRgb565  = 2'd1;
  localparam logic [ModeW-1:0] ModeRgba    = 2'd2;

  // Register indexes (byte address 4*i)
  localparam logic RegPixelMode    = 1'b0;
  localparam logic RegPaletteCount = 1'b1;

  typedef struct packed {
    logic [ModeW-1:0]  pixel_mode;
    logic [CountW-1:0] palette_count;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/pf2a_palette_ram.sv @@
// Palette memory: one write port, one registered read port.
`default_nettype none
module pf2a_palette_ram #(
  parameter int unsigned Depth = pf2a_pkg::PaletteDepthDefault,
  parameter int unsigned Width = pf2a_pkg::ColorW,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ rtl/core/pf2a_cfg_regs.sv @@
// APB register block: pixel mode and palette entry count.
`default_nettype none
module pf2a_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pf2a_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [pf2a_pkg::ApbDataW-1:0]   pwdata,
  output logic      [pf2a_pkg::ApbDataW-1:0]   prdata,
  output logic                                 pready,
  output pf2a_pkg::cfg_t                       cfg_o
);

  pf2a_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic           reg_sel;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        pf2a_pkg::RegPixelMode:    cfg_d.pixel_mode    = pwdata[pf2a_pkg::ModeW-1:0];
        pf2a_pkg::RegPaletteCount: cfg_d.palette_count = pwdata[pf2a_pkg::CountW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode    <= pf2a_pkg::ModeRgba;
      cfg_q.palette_count <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_sel)
      pf2a_pkg::RegPixelMode:
        prdata = {{(pf2a_pkg::ApbDataW - pf2a_pkg::ModeW){1'b0}}, cfg_q.pixel_mode};
      pf2a_pkg::RegPaletteCount:
        prdata = {{(pf2a_pkg::ApbDataW - pf2a_pkg::CountW){1'b0}}, cfg_q.palette_count};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ rtl/core/pixel_format_to_argb8888.sv @@
// An accepted pixel goes through stage 1 (RAM read) and then the output register.
// Throughput: one item per cycle while the output does not stall; the single palette RAM
// takes a write or a read each cycle. Palette writes are absorbed in the first stage and
// give no result. Reset clears pipeline valids, sets pixel_mode to 2 and palette_count
// to 0. Palette contents are undefined after reset, with no clearing pass; the user must
// ensure an entry is only read once written; the block itself does not enforce it.
`default_nettype none
module pixel_format_to_argb8888 #(
  parameter int unsigned PaletteDepth = pf2a_pkg::PaletteDepthDefault,
  localparam int unsigned AddrW = (PaletteDepth > 1) ? $clog2(PaletteDepth) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pf2a_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [pf2a_pkg::ApbDataW-1:0] pwdata,
  output logic      [pf2a_pkg::ApbDataW-1:0] prdata,
  output logic                               pready,
  // input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [pf2a_pkg::IndexW-1:0]   palette_index_i,
  input  wire logic [pf2a_pkg::ColorW-1:0]   palette_color_i,
  input  wire logic [pf2a_pkg::PixelW-1:0]   source_pixel_i,
  // output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [pf2a_pkg::PixelW-1:0]   argb_pixel_o
);

  localparam logic [pf2a_pkg::CountW-1:0] DepthLim = pf2a_pkg::CountW'(PaletteDepth);

  pf2a_pkg::cfg_t cfg;

  pf2a_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Stage control
  logic out_free, s1_adv, in_acc;
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || out_free;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && s1_adv;

  // Stage 0: decode, palette access, direct formats
  logic [pf2a_pkg::CountW-1:0] pix_idx, wr_idx;
  logic                        ram_we, ram_re, hit_d;
  logic [pf2a_pkg::PixelW-1:0] direct_d;
  logic [4:0]                  r5, b5;
  logic [5:0]                  g6;

  assign pix_idx = {1'b0, source_pixel_i[pf2a_pkg::IndexW-1:0]};
  assign wr_idx  = {1'b0, palette_index_i};
  assign ram_we  = in_acc && !action_i && (wr_idx < DepthLim);
  assign ram_re  = in_acc && action_i;
  assign hit_d   = (pix_idx < cfg.palette_count) && (pix_idx < DepthLim);

  assign r5 = source_pixel_i[15:11];
  assign g6 = source_pixel_i[10:5];
  assign b5 = source_pixel_i[4:0];

  always_comb begin
    unique case (cfg.pixel_mode)
      pf2a_pkg::ModeRgb565:
        direct_d = pf2a_pkg::AlphaOpaque |
                   {8'h00, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
      // RGBA, the undefined code and palette mode (unused there): swap red and blue
      default:
        direct_d = pf2a_pkg::AlphaOpaque |
                   {8'h00, source_pixel_i[7:0], source_pixel_i[15:8],
                    source_pixel_i[23:16]};
    endcase
  end

  logic [pf2a_pkg::ColorW-1:0] ram_rdata;

  pf2a_palette_ram #(
    .Depth (PaletteDepth),
    .Width (pf2a_pkg::ColorW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (palette_index_i[AddrW-1:0]),
    .wdata_i (palette_color_i),
    .re_i    (ram_re),
    .raddr_i (source_pixel_i[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Stage 1: wait for palette data
  logic                        s1_pal_q, s1_hit_q;
  logic [pf2a_pkg::PixelW-1:0] s1_direct_q;
  logic [pf2a_pkg::PixelW-1:0] s1_result;
  logic [pf2a_pkg::PixelW-1:0] argb_q;

  assign s1_valid_d  = s1_adv ? ram_re : s1_valid_q;
  assign out_valid_d = out_free ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_pal_q    <= (cfg.pixel_mode == pf2a_pkg::ModePalette);
      s1_hit_q    <= hit_d;
      s1_direct_q <= direct_d;
    end
  end

  always_comb begin
    if (!s1_pal_q) begin
      s1_result = s1_direct_q;
    end else if (s1_hit_q) begin
      s1_result = pf2a_pkg::AlphaOpaque | {8'h00, ram_rdata};
    end else begin
      s1_result = pf2a_pkg::AlphaOpaque;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      argb_q <= s1_result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign argb_pixel_o = argb_q;

`ifndef SYNTHESIS
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !action_i) |=> !s1_valid_q)
    else $error("palette write entered the result pipeline");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with an empty stage");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> out_valid_q)
    else $error("pixel lost between stage and output register");

  a_miss_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free && s1_pal_q && !s1_hit_q) |=>
      (argb_pixel_o == pf2a_pkg::AlphaOpaque))
    else $error("palette miss did not give opaque black");
`endif

endmodule
`default_nettype wire

@@ sim/tb_pixel_format_to_argb8888.sv @@
// Self-checking testbench for the palette / RGB565 / RGBA to ARGB8888 pixel converter.
`timescale 1ns / 100ps
module tb_pixel_format_to_argb8888;

  localparam logic [pf2a_pkg::ModeW-1:0] ModeUndefined = 2'd3;
  localparam logic ActWritePalette = 1'b0;
  localparam logic ActConvert      = 1'b1;
  localparam int unsigned MaxPause = 19;
  localparam int unsigned DrainCycles = 4;

  typedef struct {
    logic                        action;
    logic [pf2a_pkg::IndexW-1:0] index;
    logic [pf2a_pkg::ColorW-1:0] color;
    logic [pf2a_pkg::PixelW-1:0] pixel;
  } source_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pf2a_pkg::ApbAddrW-1:0] paddr = '0;
  logic [pf2a_pkg::ApbDataW-1:0] pwdata = '0;
  logic [pf2a_pkg::ApbDataW-1:0] prdata;
  logic                          pready;

  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic                        action_i = 1'b0;
  logic [pf2a_pkg::IndexW-1:0] palette_index_i = '0;
  logic [pf2a_pkg::ColorW-1:0] palette_color_i = '0;
  logic [pf2a_pkg::PixelW-1:0] source_pixel_i = '0;

  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [pf2a_pkg::PixelW-1:0] argb_pixel_o;

  source_item_t                source_items[$];
  logic [pf2a_pkg::PixelW-1:0] expected_argb[$];

  // register copies, only changed while the block is idle
  logic [pf2a_pkg::ModeW-1:0]  mode_reg = pf2a_pkg::ModeRgba;
  logic [pf2a_pkg::CountW-1:0] count_reg = '0;
  logic [pf2a_pkg::ColorW-1:0] palette_shadow[pf2a_pkg::PaletteDepthDefault];
  bit                          entry_loaded[pf2a_pkg::PaletteDepthDefault];

  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned stall_hold = 0;
  bit          send_steady = 1'b0;
  bit          recv_steady = 1'b0;

  pixel_format_to_argb8888 DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .palette_index_i(palette_index_i),
    .palette_color_i(palette_color_i),
    .source_pixel_i (source_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .argb_pixel_o   (argb_pixel_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [pf2a_pkg::PixelW-1:0] argb_of(
    input logic [pf2a_pkg::PixelW-1:0] src);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = src[15:11];
    g6 = src[10:5];
    b5 = src[4:0];
    case (mode_reg)
      pf2a_pkg::ModePalette: begin
        if ({1'b0, src[7:0]} < count_reg)
          return pf2a_pkg::AlphaOpaque | {8'h00, palette_shadow[src[7:0]]};
        return pf2a_pkg::AlphaOpaque;
      end
      pf2a_pkg::ModeRgb565: return {8'hff, r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
      // undefined mode falls back to the byte swap
      default: return {8'hff, src[7:0], src[15:8], src[23:16]};
    endcase
  endfunction

  // idle runs switch on and off now and then so that some stretches have no gaps
  function automatic int unsigned pause_len(inout bit steady);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, MaxPause);
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        if (action_i == ActConvert) expected_argb.push_back(argb_of(source_pixel_i));
        else palette_shadow[palette_index_i] = palette_color_i;
        void'(source_items.pop_front());
        send_gap = pause_len(send_steady);
      end
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (source_items.size() != 0) begin
        in_valid_i      <= 1'b1;
        action_i        <= source_items[0].action;
        palette_index_i <= source_items[0].index;
        palette_color_i <= source_items[0].color;
        source_pixel_i  <= source_items[0].pixel;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_argb.size() == 0) begin
          $error("argb_pixel: unexpected transfer, got %08h", argb_pixel_o);
          mismatches++;
        end else begin
          if (argb_pixel_o !== expected_argb[0]) begin
            $error("argb_pixel: expected %08h, got %08h", expected_argb[0], argb_pixel_o);
            mismatches++;
          end
          void'(expected_argb.pop_front());
        end
        stall_hold = pause_len(recv_steady);
      end else if (stall_hold != 0) begin
        stall_hold--;
      end
      out_stall_i <= (stall_hold != 0);
    end
  end

  task automatic reg_write(input logic reg_sel,
                           input logic [pf2a_pkg::ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == pf2a_pkg::RegPixelMode) mode_reg = value[pf2a_pkg::ModeW-1:0];
    else count_reg = value[pf2a_pkg::CountW-1:0];
  endtask

  task automatic set_config(input logic [pf2a_pkg::ModeW-1:0] mode, input int unsigned count);
    reg_write(pf2a_pkg::RegPixelMode, pf2a_pkg::ApbDataW'(mode));
    reg_write(pf2a_pkg::RegPaletteCount, pf2a_pkg::ApbDataW'(count));
  endtask

  task automatic queue_palette_write(input int unsigned idx,
                                     input logic [pf2a_pkg::ColorW-1:0] color);
    source_item_t it;
    it.action = ActWritePalette;
    it.index  = idx[pf2a_pkg::IndexW-1:0];
    it.color  = color;
    it.pixel  = $urandom;
    source_items.push_back(it);
    entry_loaded[idx] = 1'b1;
  endtask

  task automatic queue_pixel(input logic [pf2a_pkg::PixelW-1:0] src);
    source_item_t it;
    // an entry inside the count must be loaded before it is looked up
    if (mode_reg == pf2a_pkg::ModePalette && {1'b0, src[7:0]} < count_reg &&
        !entry_loaded[src[7:0]])
      queue_palette_write({24'd0, src[7:0]}, pf2a_pkg::ColorW'($urandom));
    it.action = ActConvert;
    it.index  = pf2a_pkg::IndexW'($urandom);
    it.color  = pf2a_pkg::ColorW'($urandom);
    it.pixel  = src;
    source_items.push_back(it);
  endtask

  // wait for every transfer to finish, then let a trailing palette write settle
  task automatic drain();
    while (source_items.size() != 0 || expected_argb.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    logic [pf2a_pkg::ModeW-1:0]  mode;
    int unsigned                 count;
    logic [pf2a_pkg::PixelW-1:0] src;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: byte swap, empty palette
    queue_pixel(32'h0000_0000);
    queue_pixel(32'hffff_ffff);
    queue_pixel(32'h1234_5678);
    queue_palette_write(0, 24'hff_ffff);
    queue_palette_write(255, 24'h5a_a53c);
    queue_palette_write(128, 24'h00_ff00);
    drain();

    // empty palette: every lookup misses
    set_config(pf2a_pkg::ModePalette, 0);
    queue_pixel(32'h0000_0000);
    queue_pixel(32'h0000_00ff);
    queue_pixel(32'hffff_ff80);
    drain();

    set_config(pf2a_pkg::ModePalette, 256);
    queue_pixel(32'hffff_ff00);
    queue_pixel(32'h0000_00ff);
    queue_pixel(32'h0000_0080);
    drain();

    // boundary of the palette count
    set_config(pf2a_pkg::ModePalette, 129);
    queue_pixel(32'h0000_0080);
    queue_pixel(32'h0000_0081);
    drain();

    set_config(pf2a_pkg::ModeRgb565, 129);
    queue_pixel(32'h0000_ffff);
    queue_pixel(32'hffff_0000);
    queue_pixel(32'h0000_f800);
    queue_pixel(32'h0000_07e0);
    queue_pixel(32'h0000_001f);
    queue_pixel(32'habcd_1234);
    drain();

    set_config(ModeUndefined, 1);
    queue_pixel(32'haabb_ccdd);
    queue_pixel(32'h00ff_00ff);
    drain();

    repeat (12) begin
      case ($urandom_range(0, 5))
        0, 1, 2: mode = pf2a_pkg::ModePalette;
        3:       mode = pf2a_pkg::ModeRgb565;
        4:       mode = pf2a_pkg::ModeRgba;
        default: mode = ModeUndefined;
      endcase
      case ($urandom_range(0, 4))
        0:       count = 0;
        1:       count = 256;
        2:       count = 1;
        default: count = $urandom_range(0, 256);
      endcase
      set_config(mode, count);
      repeat (110) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_palette_write($urandom_range(0, 255), pf2a_pkg::ColorW'($urandom));
        end else begin
          src = $urandom;
          // aim palette lookups at either side of the count boundary
          if (mode == pf2a_pkg::ModePalette) begin
            case ($urandom_range(0, 3))
              0: if (count != 0) src[7:0] = 8'(count - 1);
              1: if (count < 256) src[7:0] = 8'(count);
              default: ;
            endcase
          end
          queue_pixel(src);
        end
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS pixel_format_to_argb8888");
    end else begin
      $display("FAIL pixel_format_to_argb8888");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("FAIL pixel_format_to_argb8888");
    $finish;
  end

endmodule
